// File: rtl/s256h_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package s256h_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] hash_arr_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic       we;
      logic [3:0] addr;
      logic [3:0] be;
      word_type   wdata;
   } mem_wr_type;

   typedef struct packed {
      logic load_work;
      logic do_round;
      logic add_hash;
      logic reset_hash;
   } core_ctl_type;

   localparam hash_arr_type HASH_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type PAD_MARK = 32'h8000_0000;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type round_k(input logic [5:0] t);
      case (t)
         6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h0;
      endcase
   endfunction

endpackage

// File: rtl/s256h_block_ram.sv
// Message block buffer: 16 words with byte-lane writes and a registered read.
module s256h_block_ram (
   input  logic                   clock,
   input  s256h_pkg::mem_wr_type  wr,
   input  logic [3:0]             raddr,
   output s256h_pkg::word_type    rdata
);
   import s256h_pkg::*;

   word_type block_mem [16];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         for (int lane = 0; lane < 4; lane++) begin
            if (wr.be[lane]) begin
               block_mem[wr.addr][lane*8 +: 8] <= wr.wdata[lane*8 +: 8];
            end
         end
      end
      rd_data_ff <= block_mem[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

// File: rtl/s256h_core.sv
// Compression datapath: hash words, working variables, rolling schedule, one round per cycle.
module s256h_core (
   input  logic                    clock,
   input  logic                    reset,
   input  s256h_pkg::core_ctl_type ctl,
   input  logic [5:0]              round_index,
   input  s256h_pkg::word_type     block_word,
   input  logic [2:0]              out_index,
   output s256h_pkg::word_type     digest_word
);
   import s256h_pkg::*;

   hash_arr_type hash_ff;
   hash_arr_type work_ff;
   word_type     sched_ff [16];
   word_type     w_in;
   word_type     t1;
   word_type     t2;

   always_comb begin
      if (round_index[5:4] == 2'b00) begin
         w_in = block_word;
      end else begin
         w_in = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1])
              + sched_ff[0];
      end
      t1 = work_ff[7] + big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + round_k(round_index) + w_in;
      t2 = big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_IV;
      end else if (ctl.reset_hash) begin
         hash_ff <= HASH_IV;
      end else if (ctl.add_hash) begin
         for (int j = 0; j < 8; j++) begin
            hash_ff[j] <= hash_ff[j] + work_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_work) begin
         work_ff <= hash_ff;
      end else if (ctl.do_round) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
      if (ctl.do_round) begin
         for (int j = 0; j < 15; j++) begin
            sched_ff[j] <= sched_ff[j+1];
         end
         sched_ff[15] <= w_in;
      end
   end

   assign digest_word = hash_ff[out_index];

endmodule

// File: rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, bit count and result channel.
//
// Requests arrive on req_valid/req_ready with req_data holding one optional message
// byte and an end-of-message flag. Digests leave on rsp_valid/rsp_ready as eight
// 32-bit words, H0 first, word_index 0 to 7, last_word set on the eighth.
// A byte that does not complete a 64-byte block is written to the block buffer.
// The byte that completes a block starts a compression: a prime state for the
// block buffer read, 64 rounds at one round per cycle, then an update state that
// folds the result into the hash words. End of message writes the padding one
// buffer word per cycle, runs one or two compressions, then presents the eight
// digest words, one per accepted response.
// The block holds one request at a time: req_ready is high only when idle.
// A stalled receiver holds the current digest word and blocks new requests.
// Reset (synchronous, active high) loads the initial hash values, clears the bit
// count and returns to idle; the block buffer is not cleared.
module sha256_byte_stream_hasher (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  s256h_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output s256h_pkg::rsp_type rsp_data
);
   import s256h_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PRIME    = 3'd1;
   localparam logic [2:0] ST_ROUND    = 3'd2;
   localparam logic [2:0] ST_UPDATE   = 3'd3;
   localparam logic [2:0] ST_PADSTART = 3'd4;
   localparam logic [2:0] ST_PADZERO  = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;

   localparam logic [1:0] AFT_IDLE     = 2'd0;
   localparam logic [1:0] AFT_PADSTART = 2'd1;
   localparam logic [1:0] AFT_PADTAIL  = 2'd2;
   localparam logic [1:0] AFT_OUT      = 2'd3;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   after_ff, after_in;
   logic [63:0]  count_ff, count_in;
   logic [5:0]   round_ff, round_in;
   logic [4:0]   pad_addr_ff, pad_addr_in;
   logic         two_ff, two_in;
   logic [2:0]   out_idx_ff, out_idx_in;
   logic [5:0]   pos;
   mem_wr_type   mem_wr;
   logic [3:0]   raddr;
   word_type     rdata;
   core_ctl_type ctl;
   word_type     digest;

   assign pos = count_ff[8:3];

   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      count_in    = count_ff;
      round_in    = round_ff;
      pad_addr_in = pad_addr_ff;
      two_in      = two_ff;
      out_idx_in  = out_idx_ff;
      mem_wr      = '0;
      raddr       = '0;
      ctl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.byte_present) begin
                  mem_wr.we    = 1'b1;
                  mem_wr.addr  = pos[5:2];
                  mem_wr.be    = 4'b1000 >> pos[1:0];
                  mem_wr.wdata = {4{req_data.byte_value}};
                  count_in     = count_ff + 64'd8;
                  if (pos == 6'd63) begin
                     state_in = ST_PRIME;
                     after_in = req_data.end_of_message ? AFT_PADSTART : AFT_IDLE;
                  end else if (req_data.end_of_message) begin
                     state_in = ST_PADSTART;
                  end
               end else if (req_data.end_of_message) begin
                  state_in = ST_PADSTART;
               end
            end
         end
         ST_PRIME: begin
            ctl.load_work = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.do_round = 1'b1;
            raddr        = round_ff[3:0] + 4'd1;
            round_in     = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ctl.add_hash = 1'b1;
            case (after_ff)
               AFT_IDLE:     state_in = ST_IDLE;
               AFT_PADSTART: state_in = ST_PADSTART;
               AFT_PADTAIL: begin
                  two_in      = 1'b0;
                  pad_addr_in = '0;
                  state_in    = ST_PADZERO;
               end
               AFT_OUT: begin
                  out_idx_in = '0;
                  state_in   = ST_OUT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_PADSTART: begin
            mem_wr.we    = 1'b1;
            mem_wr.addr  = pos[5:2];
            mem_wr.be    = 4'b1111 >> pos[1:0];
            mem_wr.wdata = PAD_MARK >> {pos[1:0], 3'b000};
            pad_addr_in  = {1'b0, pos[5:2]} + 5'd1;
            two_in       = (pos[5:3] == 3'b111);
            state_in     = ST_PADZERO;
         end
         ST_PADZERO: begin
            if (pad_addr_ff[4]) begin
               state_in = ST_PRIME;
               after_in = two_ff ? AFT_PADTAIL : AFT_OUT;
            end else begin
               mem_wr.we   = 1'b1;
               mem_wr.addr = pad_addr_ff[3:0];
               mem_wr.be   = 4'b1111;
               if (two_ff) begin
                  mem_wr.wdata = '0;
               end else if (pad_addr_ff[3:0] == 4'd14) begin
                  mem_wr.wdata = count_ff[63:32];
               end else if (pad_addr_ff[3:0] == 4'd15) begin
                  mem_wr.wdata = count_ff[31:0];
               end else begin
                  mem_wr.wdata = '0;
               end
               pad_addr_in = pad_addr_ff + 5'd1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  ctl.reset_hash = 1'b1;
                  count_in       = '0;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         after_ff    <= AFT_IDLE;
         count_ff    <= '0;
         round_ff    <= '0;
         pad_addr_ff <= '0;
         two_ff      <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         after_ff    <= after_in;
         count_ff    <= count_in;
         round_ff    <= round_in;
         pad_addr_ff <= pad_addr_in;
         two_ff      <= two_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   s256h_block_ram u_block_ram (
      .clock (clock),
      .wr    (mem_wr),
      .raddr (raddr),
      .rdata (rdata)
   );

   s256h_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .round_index (round_ff),
      .block_word  (rdata),
      .out_index   (out_idx_ff),
      .digest_word (digest)
   );

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_data.digest_word = digest;
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == 3'd7);

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response channels open together");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_word |-> rsp_data.word_index == 3'd7)
      else $error("last word flagged at wrong index");

   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_word |=> req_ready && count_ff == 64'd0)
      else $error("not idle with cleared count after digest");

   a_round_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRIME |=> state_ff == ST_ROUND && round_ff == 6'd0)
      else $error("compression did not start at round zero");

endmodule
